// ----- src/sfl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sfl_pkg;

	localparam int PAGE_BYTES = 128;
	localparam int PAGE_WORDS = (PAGE_BYTES + 3) / 4;
	localparam int BI_W = $clog2(PAGE_BYTES);
	localparam int WI_W = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;

	localparam logic [23:0] TIMEOUT_RESET = 24'hF_FFFF;
	localparam logic [31:0] BOOT_RESET = 32'h0000_7000;
	localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

	localparam logic [7:0] CH_ACK = 8'h59;
	localparam logic [7:0] CH_PING = 8'h61;
	localparam logic [7:0] CH_FILL = 8'h62;
	localparam logic [7:0] CH_PROG = 8'h63;
	localparam logic [7:0] CH_ERASE = 8'h64;
	localparam logic [7:0] CH_START = 8'h78;

	localparam logic [1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_BOOT = 2'd1;

	typedef enum logic [2:0] {
		OP_SEND = 3'd0,
		OP_FILL = 3'd1,
		OP_WRITE = 3'd2,
		OP_ERASE = 3'd3,
		OP_START = 3'd4
	} op_t;

	typedef enum logic [3:0] {
		ST_WAIT,
		ST_CMD,
		ST_DATA,
		ST_ADDR,
		ST_ERASE_ACK,
		ST_FILL_RD,
		ST_FILL,
		ST_PWRITE,
		ST_PACK,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		EM_ACK,
		EM_START,
		EM_ERASE,
		EM_FILL,
		EM_WRITE
	} emit_t;

	typedef struct packed {
		logic  cnt_inc;
		logic  byte_store;
		logic  byte_clr;
		logic  addr_clr;
		logic  addr_store;
		logic  widx_clr;
		logic  widx_adv;
		logic  emit;
		emit_t emit_kind;
		logic  emit_last;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic wait_timeout;
		logic byte_last;
		logic addr_last;
		logic word_last;
	} status_t;

endpackage
`default_nettype wire

// ----- src/sfl_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface sfl_req_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] rx_byte;

	modport source (output valid, output mode, output rx_byte, input ready);
	modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface sfl_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  op;
	logic [7:0]  tx_byte;
	logic [31:0] address;
	logic [31:0] fill_data;
	logic        last;

	modport source (output valid, output op, output tx_byte, output address,
		output fill_data, output last, input ready);
	modport sink (input valid, input op, input tx_byte, input address,
		input fill_data, input last, output ready);
endinterface

interface sfl_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/sfl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sfl_ctrl
	import sfl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	sfl_req_if.sink   req,
	input  status_t   status,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;
	logic   take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WAIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.emit_kind = EM_ACK;
		req.ready = 1'b0;
		case (state_q)
			ST_WAIT: begin
				req.ready = status.slot_free;
				if (take) begin
					if (req.mode) begin
						if (status.wait_timeout) begin
							cmd.emit = 1'b1;
							cmd.emit_kind = EM_START;
							cmd.emit_last = 1'b1;
							state_d = ST_DONE;
						end else begin
							cmd.cnt_inc = 1'b1;
						end
					end else if (req.rx_byte == CH_PING) begin
						cmd.emit = 1'b1;
						cmd.emit_last = 1'b1;
						state_d = ST_CMD;
					end else begin
						cmd.emit = 1'b1;
						cmd.emit_kind = EM_START;
						cmd.emit_last = 1'b1;
						state_d = ST_DONE;
					end
				end
			end
			ST_CMD: begin
				req.ready = status.slot_free;
				if (take && !req.mode) begin
					case (req.rx_byte)
						CH_PING: begin
							cmd.emit = 1'b1;
							cmd.emit_last = 1'b1;
						end
						CH_FILL: begin
							cmd.emit = 1'b1;
							cmd.emit_last = 1'b1;
							cmd.byte_clr = 1'b1;
							state_d = ST_DATA;
						end
						CH_PROG: begin
							cmd.emit = 1'b1;
							cmd.emit_last = 1'b1;
							cmd.addr_clr = 1'b1;
							state_d = ST_ADDR;
						end
						CH_ERASE: begin
							cmd.emit = 1'b1;
							cmd.emit_kind = EM_ERASE;
							state_d = ST_ERASE_ACK;
						end
						CH_START: begin
							cmd.emit = 1'b1;
							cmd.emit_kind = EM_START;
							cmd.emit_last = 1'b1;
							state_d = ST_DONE;
						end
						default: begin
						end
					endcase
				end
			end
			ST_DATA: begin
				req.ready = 1'b1;
				if (take && !req.mode) begin
					cmd.byte_store = 1'b1;
					if (status.byte_last) begin
						state_d = ST_CMD;
					end
				end
			end
			ST_ADDR: begin
				req.ready = 1'b1;
				if (take && !req.mode) begin
					cmd.addr_store = 1'b1;
					if (status.addr_last) begin
						cmd.widx_clr = 1'b1;
						state_d = ST_FILL_RD;
					end
				end
			end
			ST_ERASE_ACK: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					state_d = ST_CMD;
				end
			end
			// first page word is being read
			ST_FILL_RD: begin
				state_d = ST_FILL;
			end
			ST_FILL: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = EM_FILL;
					if (status.word_last) begin
						state_d = ST_PWRITE;
					end else begin
						cmd.widx_adv = 1'b1;
					end
				end
			end
			ST_PWRITE: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					cmd.emit_kind = EM_WRITE;
					state_d = ST_PACK;
				end
			end
			ST_PACK: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					cmd.emit_last = 1'b1;
					state_d = ST_CMD;
				end
			end
			ST_DONE: begin
				// drop everything
				req.ready = 1'b1;
			end
			default: begin
				state_d = ST_WAIT;
			end
		endcase
	end

	assign take = req.valid && req.ready;

`ifndef NO_ASSERTIONS
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.slot_free)
		else $error("result issued while output register is occupied");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> state_q == ST_DONE)
		else $error("left finished state");

	a_addr_to_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR && take && !req.mode && status.addr_last)
		|=> state_q == ST_FILL_RD)
		else $error("page program did not start after address");

	a_no_take_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL || state_q == ST_PWRITE || state_q == ST_PACK)
		|-> !req.ready)
		else $error("input accepted during page program burst");
`endif

endmodule
`default_nettype wire

// ----- src/sfl_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sfl_dp
	import sfl_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] rx_byte,
	input  cmd_t            cmd,
	output status_t         status,
	sfl_rsp_if.source       rsp,
	sfl_cfg_if.sink         cfg
);

	logic [23:0]     limit_q;
	logic [31:0]     boot_q;
	logic [23:0]     wait_q;
	logic [BI_W-1:0] byte_idx_q;
	logic [31:0]     page_addr_q;
	logic [1:0]      addr_seen_q;
	logic [WI_W-1:0] widx_q;
	logic [WI_W-1:0] rd_idx;
	logic [WI_W-1:0] wr_idx;
	logic [31:0]     mem_q [PAGE_WORDS];
	logic [31:0]     rdata_q;
	logic [31:0]     lane_mask;
	logic [31:0]     word_base;

	logic            out_valid_q;
	op_t             op_q;
	logic [7:0]      tx_q;
	logic [31:0]     addr_out_q;
	logic [31:0]     data_q;
	logic            last_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= TIMEOUT_RESET;
			boot_q <= BOOT_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_TIMEOUT) begin
				limit_q <= cfg.data[23:0];
			end else if (cfg.index == CFG_BOOT) begin
				boot_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= '0;
			byte_idx_q <= '0;
			page_addr_q <= '0;
			addr_seen_q <= '0;
			widx_q <= '0;
		end else begin
			// saturate at the top of the range
			if (cmd.cnt_inc && wait_q != COUNT_MAX) begin
				wait_q <= wait_q + 24'd1;
			end
			if (cmd.byte_clr || (cmd.byte_store && status.byte_last)) begin
				byte_idx_q <= '0;
			end else if (cmd.byte_store) begin
				byte_idx_q <= byte_idx_q + 1'b1;
			end
			if (cmd.addr_clr) begin
				page_addr_q <= '0;
				addr_seen_q <= '0;
			end else if (cmd.addr_store) begin
				page_addr_q <= page_addr_q | (32'(rx_byte) << {addr_seen_q, 3'b000});
				addr_seen_q <= addr_seen_q + 2'd1;
			end
			if (cmd.widx_clr) begin
				widx_q <= '0;
			end else if (cmd.widx_adv) begin
				widx_q <= widx_q + 1'b1;
			end
		end
	end

	assign wr_idx = WI_W'(byte_idx_q >> 2);
	assign rd_idx = cmd.widx_adv ? widx_q + 1'b1 : widx_q;

	always_ff @(posedge clk) begin
		if (cmd.byte_store) begin
			mem_q[wr_idx][{byte_idx_q[1:0], 3'b000} +: 8] <= rx_byte;
		end
		rdata_q <= mem_q[rd_idx];
	end

	assign word_base = 32'(widx_q) << 2;

	// zero the byte lanes past the end of the page
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			lane_mask[j*8 +: 8] = (word_base + 32'(j) < 32'(PAGE_BYTES)) ? 8'hFF : 8'h00;
		end
	end

	assign status.slot_free = !out_valid_q || rsp.ready;
	assign status.wait_timeout = wait_q > limit_q;
	assign status.byte_last = byte_idx_q == BI_W'(PAGE_BYTES - 1);
	assign status.addr_last = addr_seen_q == 2'd3;
	assign status.word_last = widx_q == WI_W'(PAGE_WORDS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			last_q <= cmd.emit_last;
			tx_q <= 8'h00;
			addr_out_q <= '0;
			data_q <= '0;
			case (cmd.emit_kind)
				EM_ACK: begin
					op_q <= OP_SEND;
					tx_q <= CH_ACK;
				end
				EM_START: begin
					op_q <= OP_START;
				end
				EM_ERASE: begin
					op_q <= OP_ERASE;
					addr_out_q <= boot_q;
				end
				EM_FILL: begin
					op_q <= OP_FILL;
					addr_out_q <= page_addr_q + word_base;
					data_q <= rdata_q & lane_mask;
				end
				EM_WRITE: begin
					op_q <= OP_WRITE;
					addr_out_q <= page_addr_q;
				end
				default: begin
					op_q <= OP_START;
				end
			endcase
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.op = op_q;
	assign rsp.tx_byte = tx_q;
	assign rsp.address = addr_out_q;
	assign rsp.fill_data = data_q;
	assign rsp.last = last_q;

`ifndef NO_ASSERTIONS
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> out_valid_q)
		else $error("pending result lost while stalled");

	a_seen_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.addr_store && addr_seen_q == 2'd3) |=> addr_seen_q == 2'd0)
		else $error("address byte count did not wrap");

	a_fill_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.widx_adv |-> widx_q != WI_W'(PAGE_WORDS - 1))
		else $error("word index advanced past the page");
`endif

endmodule
`default_nettype wire

// ----- src/serial_flash_loader_command_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Command engine of a serial flash loader.
// req carries one item per transaction: mode 0 is a received byte (rx_byte),
// mode 1 is an idle tick. rsp carries the resulting operations (send byte,
// page fill, page write, erase range, start application); last marks the
// final result of one input item. cfg writes timeout_limit (index 0) and
// boot_start (index 1); it is always ready. A byte or tick that causes no
// result, or one result, is handled in the cycle it is accepted. An erase
// command issues the erase range and then, once the output register is free,
// an ack. The final address byte of a program command reads the page store
// one word per cycle while rsp.ready is high: a first read, PAGE_BYTES/4
// fills, a page write and an ack.
// The output register holds one result; req.ready drops while that register
// is full and rsp.ready is low in states that would issue a result, and the
// page program burst simply waits on rsp.ready.
// Reset clears state to waiting for the first byte and restores the register
// defaults. The page store is not cleared; reading bytes never loaded
// returns whatever it holds.
module serial_flash_loader_command_engine
	import sfl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	sfl_req_if.sink   req,
	sfl_rsp_if.source rsp,
	sfl_cfg_if.sink   cfg
);

	cmd_t    cmd;
	status_t status;

	sfl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.status (status),
		.cmd    (cmd)
	);

	sfl_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (req.rx_byte),
		.cmd     (cmd),
		.status  (status),
		.rsp     (rsp),
		.cfg     (cfg)
	);

endmodule
`default_nettype wire
